FILE: hdl/three_vector_alu_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-vector ALU unit
// Shared shorthand for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef THREE_VECTOR_ALU_UNIT_MACROS_SVH
`define THREE_VECTOR_ALU_UNIT_MACROS_SVH

// same-cycle implication
`define TVA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tva assertion failed");

// next-cycle implication
`define TVA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tva assertion failed");

`endif

FILE: hdl/tva_pkg.sv
// ----------------------------------------------------------------------------
// tva_pkg
// Widths, types and helper functions of the three-vector ALU.
// ----------------------------------------------------------------------------
package tva_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int FW = 32;
    localparam int W  = (WORD_BITS < FW) ? WORD_BITS : FW;
    localparam int NL = 3;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;
    localparam int SW = ((2 * W + 3) > (W + FRAC_BITS + 2)) ?
                        (2 * W + 3) : (W + FRAC_BITS + 2);
    localparam int QW = W + FRAC_BITS;

    typedef enum logic [2:0] {
        MODE_ADD, MODE_SUB, MODE_SCALE, MODE_DIV,
        MODE_DOT, MODE_CROSS, MODE_LEN, MODE_NORM
    } t_mode;

    typedef logic signed [W-1:0]  t_word;
    typedef logic        [W-1:0]  t_uword;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [SW-1:0] t_wide;
    typedef logic        [PW-1:0] t_sq;
    typedef logic        [QW-1:0] t_quo;

    localparam t_word W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(W-1){1'b0}}};
    localparam t_wide HALF  = t_wide'(1) <<< (FRAC_BITS - 1);

    typedef struct packed {
        t_mode         mode;
        t_word [NL-1:0] a;
        t_word [NL-1:0] b;
        t_word         s;
    } t_item;

    typedef struct packed {
        t_word p_a;
        t_word p_b;
        t_word q_a;
        t_word q_b;
    } t_mul_ops;

    typedef struct packed {
        t_mode          mode;
        t_word [NL-1:0] a;
        t_word          s;
        t_word [NL-1:0] r;
        t_word          rs;
        logic           flag;
        logic           use_q;
        logic [NL-1:0]  q_neg;
    } t_side;

    typedef struct packed {
        logic  ovf;
        t_word val;
    } t_sat;

    function automatic t_wide wide(input t_word x);
        return t_wide'(x);
    endfunction

    function automatic t_sat sat_w(input t_wide v);
        t_sat res;
        if (v > wide(W_MAX)) begin
            res.ovf = 1'b1;
            res.val = W_MAX;
        end else if (v < wide(W_MIN)) begin
            res.ovf = 1'b1;
            res.val = W_MIN;
        end else begin
            res.ovf = 1'b0;
            res.val = v[W-1:0];
        end
        return res;
    endfunction

    // floor((v + half) / 2^FRAC_BITS)
    function automatic t_wide rnd(input t_wide v);
        return (v + HALF) >>> FRAC_BITS;
    endfunction

    function automatic t_uword mag(input t_word x);
        return x[W-1] ? t_uword'(~x + t_word'(1)) : t_uword'(x);
    endfunction

endpackage

FILE: hdl/tva_lane.sv
// ----------------------------------------------------------------------------
// tva_lane
// One arithmetic lane: two registered products and their registered difference.
// ----------------------------------------------------------------------------
module tva_lane (
    input  logic               i_clk,
    input  tva_pkg::t_mul_ops  i_ops,
    output tva_pkg::t_diff     o_diff
);

    tva_pkg::t_prod r_p;
    tva_pkg::t_prod r_q;
    tva_pkg::t_diff r_diff;

    always_ff @(posedge i_clk) begin
        r_p    <= tva_pkg::t_prod'(i_ops.p_a) * tva_pkg::t_prod'(i_ops.p_b);
        r_q    <= tva_pkg::t_prod'(i_ops.q_a) * tva_pkg::t_prod'(i_ops.q_b);
        r_diff <= tva_pkg::t_diff'(r_p) - tva_pkg::t_diff'(r_q);
    end

    assign o_diff = r_diff;

endmodule

FILE: hdl/tva_sqrt.sv
// ----------------------------------------------------------------------------
// tva_sqrt
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module tva_sqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tva_pkg::t_sq     i_val,
    input  tva_pkg::t_side   i_side,
    output logic             o_valid,
    output tva_pkg::t_uword  o_root,
    output tva_pkg::t_side   o_side
);

    localparam int NS = tva_pkg::W;
    localparam int RW = tva_pkg::W + 2;
    localparam int TW = tva_pkg::W + 4;

    logic             r_v    [0:NS];
    tva_pkg::t_sq     r_rad  [0:NS];
    logic [RW-1:0]    r_rem  [0:NS];
    tva_pkg::t_uword  r_root [0:NS];
    tva_pkg::t_side   r_side [0:NS];

    logic [TW-1:0]    n_t    [0:NS-1];
    logic [TW-1:0]    n_tr   [0:NS-1];
    logic [TW-1:0]    n_sub  [0:NS-1];
    logic             n_ge   [0:NS-1];

    logic             r_out_v;
    tva_pkg::t_uword  r_out_root;
    tva_pkg::t_side   r_out_side;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            n_t[k]   = {r_rem[k], r_rad[k][tva_pkg::PW-1 -: 2]};
            n_tr[k]  = {2'b00, r_root[k], 2'b01};
            n_ge[k]  = (n_t[k] >= n_tr[k]);
            n_sub[k] = n_t[k] - n_tr[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NS; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_out_v <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= i_val;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= i_side;
        for (int k = 0; k < NS; k++) begin
            r_rad[k+1]  <= r_rad[k] << 2;
            r_rem[k+1]  <= n_ge[k] ? n_sub[k][RW-1:0] : n_t[k][RW-1:0];
            r_root[k+1] <= {r_root[k][tva_pkg::W-2:0], n_ge[k]};
            r_side[k+1] <= r_side[k];
        end
        r_out_root <= (r_rem[NS] > RW'(r_root[NS])) ? r_root[NS] + tva_pkg::t_uword'(1)
                                                     : r_root[NS];
        r_out_side <= r_side[NS];
    end

    assign o_valid = r_out_v;
    assign o_root  = r_out_root;
    assign o_side  = r_out_side;

endmodule

FILE: hdl/tva_div.sv
// ----------------------------------------------------------------------------
// tva_div
// Pipelined restoring divider, one quotient bit per stage, one divisor
// shared by all lanes.
// ----------------------------------------------------------------------------
module tva_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tva_pkg::t_quo    i_num [0:tva_pkg::NL-1],
    input  tva_pkg::t_uword  i_den,
    input  tva_pkg::t_side   i_side,
    output logic             o_valid,
    output tva_pkg::t_quo    o_quo [0:tva_pkg::NL-1],
    output tva_pkg::t_side   o_side
);

    localparam int NS = tva_pkg::QW;
    localparam int NL = tva_pkg::NL;
    localparam int W  = tva_pkg::W;

    logic             r_v    [0:NS];
    tva_pkg::t_quo    r_n    [0:NS][0:NL-1];
    tva_pkg::t_uword  r_rem  [0:NS][0:NL-1];
    tva_pkg::t_quo    r_q    [0:NS][0:NL-1];
    tva_pkg::t_uword  r_d    [0:NS];
    tva_pkg::t_side   r_side [0:NS];

    logic [W:0]       n_t    [0:NS-1][0:NL-1];
    logic [W:0]       n_sub  [0:NS-1][0:NL-1];
    logic             n_ge   [0:NS-1][0:NL-1];

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < NL; l++) begin
                n_t[k][l]   = {r_rem[k][l], r_n[k][l][NS-1]};
                n_ge[k][l]  = (n_t[k][l] >= {1'b0, r_d[k]});
                n_sub[k][l] = n_t[k][l] - {1'b0, r_d[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NS; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r_n[0][l]   <= i_num[l];
            r_rem[0][l] <= '0;
            r_q[0][l]   <= '0;
        end
        r_d[0]    <= i_den;
        r_side[0] <= i_side;
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < NL; l++) begin
                r_n[k+1][l]   <= {r_n[k][l][NS-2:0], 1'b0};
                r_rem[k+1][l] <= n_ge[k][l] ? n_sub[k][l][W-1:0] : n_t[k][l][W-1:0];
                r_q[k+1][l]   <= {r_q[k][l][NS-2:0], n_ge[k][l]};
            end
            r_d[k+1]    <= r_d[k];
            r_side[k+1] <= r_side[k];
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            o_quo[l] = r_q[NS][l];
        end
    end

    assign o_valid = r_v[NS];
    assign o_side  = r_side[NS];

endmodule

FILE: hdl/three_vector_alu_unit.sv
// ----------------------------------------------------------------------------
// three_vector_alu_unit
// Q16.16 three-component vector ALU: add, sub, scale, divide, dot, cross,
// length and normalize, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A word is accepted on each rising edge with start high and busy low.
//   busy is held low: the pipeline takes one word every cycle.
//   Every accepted word gives exactly one result word, shown for one cycle
//   with o_valid high, in the order the words went in.
//   Every mode travels through the square root (one root bit per stage, W
//   stages) and then the divider (one quotient bit per stage, W + FRAC_BITS
//   stages, FRAC_BITS being 16 for Q16.16), so results stay in order.
//   Three lanes form the products in parallel; a merge stage sums and rounds.
//   The receiver cannot stall; results are dropped if not taken.
//   Synchronous reset clears all valid bits; words in flight are discarded.
// ----------------------------------------------------------------------------
`include "three_vector_alu_unit_macros.svh"

module three_vector_alu_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [2:0]  i_mode,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_scalar_in,
    output logic               o_valid,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic signed [31:0] o_r_scalar,
    output logic               o_range_error
);

    localparam int NL = tva_pkg::NL;
    localparam int W  = tva_pkg::W;
    localparam int FB = tva_pkg::FRAC_BITS;

    logic                r_s1_v, r_s2_v, r_s3_v;
    tva_pkg::t_item      r_s1, r_s2, r_s3;
    tva_pkg::t_mul_ops   w_ops  [0:NL-1];
    tva_pkg::t_diff      w_diff [0:NL-1];

    logic                r_m_v;
    tva_pkg::t_side      r_m_side, n_m_side;
    tva_pkg::t_sq        r_m_sq, n_m_sq;

    logic                w_sq_v;
    tva_pkg::t_uword     w_root;
    tva_pkg::t_side      w_sq_side;

    logic                r_p_v;
    tva_pkg::t_side      r_p_side, n_p_side;
    tva_pkg::t_quo       r_p_num [0:NL-1];
    tva_pkg::t_quo       n_p_num [0:NL-1];
    tva_pkg::t_uword     r_p_den, n_p_den;

    logic                w_dv_v;
    tva_pkg::t_quo       w_quo [0:NL-1];
    tva_pkg::t_side      w_dv_side;

    logic                r_o_v;
    tva_pkg::t_word      r_o_r [0:NL-1];
    tva_pkg::t_word      n_o_r [0:NL-1];
    tva_pkg::t_word      r_o_rs;
    logic                r_o_flag, n_o_flag;

    assign busy = 1'b0;

    // valid bits of every stage outside the square root and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_m_v  <= 1'b0;
            r_p_v  <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_s1_v <= start && !busy;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_m_v  <= r_s3_v;
            r_p_v  <= w_sq_v;
            r_o_v  <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_s1.mode <= tva_pkg::t_mode'(i_mode);
            r_s1.a[0] <= i_a_x[W-1:0];
            r_s1.a[1] <= i_a_y[W-1:0];
            r_s1.a[2] <= i_a_z[W-1:0];
            r_s1.b[0] <= i_b_x[W-1:0];
            r_s1.b[1] <= i_b_y[W-1:0];
            r_s1.b[2] <= i_b_z[W-1:0];
            r_s1.s    <= i_scalar_in[W-1:0];
        end
        r_s2     <= r_s1;
        r_s3     <= r_s2;
        r_m_side <= n_m_side;
        r_m_sq   <= n_m_sq;
        r_p_side <= n_p_side;
        r_p_den  <= n_p_den;
        for (int l = 0; l < NL; l++) begin
            r_p_num[l] <= n_p_num[l];
            r_o_r[l]   <= n_o_r[l];
        end
        r_o_rs   <= w_dv_side.rs;
        r_o_flag <= n_o_flag;
    end

    // lane operand select: each lane forms p_a*p_b - q_a*q_b
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            w_ops[l] = '0;
        end
        case (r_s1.mode)
            tva_pkg::MODE_SCALE: begin
                for (int l = 0; l < NL; l++) begin
                    w_ops[l].p_a = r_s1.a[l];
                    w_ops[l].p_b = r_s1.s;
                end
            end
            tva_pkg::MODE_DOT: begin
                for (int l = 0; l < NL; l++) begin
                    w_ops[l].p_a = r_s1.a[l];
                    w_ops[l].p_b = r_s1.b[l];
                end
            end
            tva_pkg::MODE_CROSS: begin
                w_ops[0] = '{p_a: r_s1.a[1], p_b: r_s1.b[2], q_a: r_s1.b[1], q_b: r_s1.a[2]};
                w_ops[1] = '{p_a: r_s1.b[0], p_b: r_s1.a[2], q_a: r_s1.a[0], q_b: r_s1.b[2]};
                w_ops[2] = '{p_a: r_s1.a[0], p_b: r_s1.b[1], q_a: r_s1.b[0], q_b: r_s1.a[1]};
            end
            tva_pkg::MODE_LEN, tva_pkg::MODE_NORM: begin
                for (int l = 0; l < NL; l++) begin
                    w_ops[l].p_a = r_s1.a[l];
                    w_ops[l].p_b = r_s1.a[l];
                end
            end
            default: begin
                for (int l = 0; l < NL; l++) begin
                    w_ops[l] = '0;
                end
            end
        endcase
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        tva_lane u_lane (
            .i_clk  (i_clk),
            .i_ops  (w_ops[g]),
            .o_diff (w_diff[g])
        );
    end

    // merge: sums, rounding and saturation of add, sub, scale, dot and cross, and the sum of squares
    always_comb begin
        tva_pkg::t_wide v_sum;
        tva_pkg::t_sat  v_st;
        n_m_side       = '0;
        n_m_side.mode  = r_s3.mode;
        n_m_side.a     = r_s3.a;
        n_m_side.s     = r_s3.s;
        v_sum = tva_pkg::t_wide'(w_diff[0]) + tva_pkg::t_wide'(w_diff[1])
              + tva_pkg::t_wide'(w_diff[2]);
        v_st  = '0;
        n_m_sq = v_sum[tva_pkg::PW-1:0];
        case (r_s3.mode)
            tva_pkg::MODE_ADD: begin
                for (int l = 0; l < NL; l++) begin
                    v_st = tva_pkg::sat_w(tva_pkg::wide(r_s3.a[l]) + tva_pkg::wide(r_s3.b[l]));
                    n_m_side.r[l] = v_st.val;
                    n_m_side.flag = n_m_side.flag | v_st.ovf;
                end
            end
            tva_pkg::MODE_SUB: begin
                for (int l = 0; l < NL; l++) begin
                    v_st = tva_pkg::sat_w(tva_pkg::wide(r_s3.a[l]) - tva_pkg::wide(r_s3.b[l]));
                    n_m_side.r[l] = v_st.val;
                    n_m_side.flag = n_m_side.flag | v_st.ovf;
                end
            end
            tva_pkg::MODE_SCALE, tva_pkg::MODE_CROSS: begin
                for (int l = 0; l < NL; l++) begin
                    v_st = tva_pkg::sat_w(tva_pkg::rnd(tva_pkg::t_wide'(w_diff[l])));
                    n_m_side.r[l] = v_st.val;
                    n_m_side.flag = n_m_side.flag | v_st.ovf;
                end
            end
            tva_pkg::MODE_DOT: begin
                v_st = tva_pkg::sat_w(tva_pkg::rnd(v_sum));
                n_m_side.rs   = v_st.val;
                n_m_side.flag = v_st.ovf;
            end
            default: begin
                n_m_side.flag = 1'b0;
            end
        endcase
    end

    tva_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_v),
        .i_val   (r_m_sq),
        .i_side  (r_m_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // divider setup: divisor, rounded dividends, the length result and the special cases
    always_comb begin
        tva_pkg::t_sat v_st;
        n_p_side = w_sq_side;
        n_p_den  = tva_pkg::t_uword'(1);
        v_st     = '0;
        case (w_sq_side.mode)
            tva_pkg::MODE_LEN: begin
                v_st = tva_pkg::sat_w(tva_pkg::t_wide'(w_root));
                n_p_side.rs   = v_st.val;
                n_p_side.flag = v_st.ovf;
            end
            tva_pkg::MODE_DIV: begin
                if (w_sq_side.s == '0) begin
                    n_p_side.flag = 1'b1;
                    for (int l = 0; l < NL; l++) begin
                        if (w_sq_side.a[l][W-1]) begin
                            n_p_side.r[l] = tva_pkg::W_MIN;
                        end else if (w_sq_side.a[l] != '0) begin
                            n_p_side.r[l] = tva_pkg::W_MAX;
                        end else begin
                            n_p_side.r[l] = '0;
                        end
                    end
                end else begin
                    n_p_side.use_q = 1'b1;
                    n_p_den        = tva_pkg::mag(w_sq_side.s);
                    for (int l = 0; l < NL; l++) begin
                        n_p_side.q_neg[l] = w_sq_side.a[l][W-1] ^ w_sq_side.s[W-1];
                    end
                end
            end
            tva_pkg::MODE_NORM: begin
                if (w_root == '0) begin
                    n_p_side.r = w_sq_side.a;
                end else begin
                    n_p_side.use_q = 1'b1;
                    n_p_den        = w_root;
                    for (int l = 0; l < NL; l++) begin
                        n_p_side.q_neg[l] = w_sq_side.a[l][W-1];
                    end
                end
            end
            default: begin
                n_p_side.use_q = 1'b0;
            end
        endcase
        for (int l = 0; l < NL; l++) begin
            n_p_num[l] = {tva_pkg::mag(w_sq_side.a[l]), {FB{1'b0}}}
                       + tva_pkg::t_quo'(n_p_den >> 1);
        end
    end

    tva_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_v),
        .i_num   (r_p_num),
        .i_den   (r_p_den),
        .i_side  (r_p_side),
        .o_valid (w_dv_v),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // result select: sign and saturate the quotients
    always_comb begin
        tva_pkg::t_wide v_q;
        tva_pkg::t_sat  v_st;
        n_o_flag = w_dv_side.flag;
        v_q      = '0;
        v_st     = '0;
        for (int l = 0; l < NL; l++) begin
            n_o_r[l] = w_dv_side.r[l];
            if (w_dv_side.use_q) begin
                v_q = tva_pkg::t_wide'(w_quo[l]);
                if (w_dv_side.q_neg[l]) begin
                    v_q = -v_q;
                end
                v_st     = tva_pkg::sat_w(v_q);
                n_o_r[l] = v_st.val;
                n_o_flag = n_o_flag | v_st.ovf;
            end
        end
    end

    assign o_valid       = r_o_v;
    assign o_r_x         = 32'(r_o_r[0]);
    assign o_r_y         = 32'(r_o_r[1]);
    assign o_r_z         = 32'(r_o_r[2]);
    assign o_r_scalar    = 32'(r_o_rs);
    assign o_range_error = r_o_flag;

    `TVA_ASSERT_NXT(a_lane_adv, i_clk, i_rst_n, r_s2_v, r_s3_v)
    `TVA_ASSERT_IMP(a_den_nz, i_clk, i_rst_n, r_p_v && r_p_side.use_q, r_p_den != '0)
    `TVA_ASSERT_NXT(a_out_strobe, i_clk, i_rst_n, w_dv_v, r_o_v)

endmodule

FILE: test/three_vector_alu_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_vector_alu_unit_test
// Drives directed and random words through every mode of the vector ALU, with
// random start gaps between random words, predicts each result in the testbench
// and compares it field by field with the words leaving the block.
// ----------------------------------------------------------------------------
module three_vector_alu_unit_test;

    localparam int FB = 16;
    localparam longint WMAXL = 64'sd2147483647;
    localparam longint WMINL = -64'sd2147483648;
    localparam int LATENCY = 89;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_scalar;
        logic               range_error;
    } t_vec_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic        [2:0]  i_mode = '0;
    logic signed [31:0] i_a_x = '0;
    logic signed [31:0] i_a_y = '0;
    logic signed [31:0] i_a_z = '0;
    logic signed [31:0] i_b_x = '0;
    logic signed [31:0] i_b_y = '0;
    logic signed [31:0] i_b_z = '0;
    logic signed [31:0] i_scalar_in = '0;
    logic               o_valid;
    logic signed [31:0] o_r_x;
    logic signed [31:0] o_r_y;
    logic signed [31:0] o_r_z;
    logic signed [31:0] o_r_scalar;
    logic               o_range_error;

    t_vec_result pending_results[$];
    int          errors = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          mode_count[8];
    int          cycles = 0;
    logic        sat_flag;

    three_vector_alu_unit u_top (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[three_vector_alu_unit] ERROR");
            $finish;
        end
    end

    function automatic longint clamp(input longint v);
        if (v > WMAXL) begin
            sat_flag = 1'b1;
            return WMAXL;
        end
        if (v < WMINL) begin
            sat_flag = 1'b1;
            return WMINL;
        end
        return v;
    endfunction

    // floor((sum + half) / 2^FB); sums fit in 66 bits for 32-bit operands
    function automatic longint round_prod(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = (v + (66'sd1 <<< (FB - 1))) >>> FB;
        if (t > 66'sd2147483647 * 4) return 64'sh7fffffffffff;
        if (t < -66'sd2147483648 * 4) return -64'sh7fffffffffff;
        return longint'(t);
    endfunction

    function automatic longint quot_round(input longint num, input longint unsigned den);
        longint unsigned m;
        logic [95:0]     q;
        m = (num < 0) ? longint'(-num) : num;
        q = ((96'(m) << FB) + 96'(den / 2)) / 96'(den);
        if (q > 96'h7fffffffffff) q = 96'h7fffffffffff;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root_round(input longint unsigned v);
        longint unsigned s, t;
        s = 0;
        for (int b = 31; b >= 0; b--) begin
            t = s | (64'd1 << b);
            if (t * t <= v) s = t;
        end
        if (v - s * s > s) s++;
        return s;
    endfunction

    function automatic t_vec_result predict_alu(input tva_pkg::t_mode mode,
            input longint a[3], input longint b[3], input longint s);
        t_vec_result res;
        longint r[3];
        longint rs;
        longint q;
        longint unsigned sq, len;
        logic signed [65:0] acc;
        r = '{0, 0, 0};
        rs = 0;
        sat_flag = 1'b0;
        case (mode)
            tva_pkg::MODE_ADD: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i]);
            tva_pkg::MODE_SUB: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i]);
            tva_pkg::MODE_SCALE: begin
                for (int i = 0; i < 3; i++) r[i] = clamp(round_prod(66'(a[i] * s)));
            end
            tva_pkg::MODE_DIV: begin
                if (s == 0) begin
                    sat_flag = 1'b1;
                    for (int i = 0; i < 3; i++)
                        r[i] = (a[i] > 0) ? WMAXL : ((a[i] < 0) ? WMINL : 0);
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        q = quot_round(a[i], (s < 0) ? -s : s);
                        r[i] = clamp((s < 0) ? -q : q);
                    end
                end
            end
            tva_pkg::MODE_DOT: begin
                acc = 66'(a[0] * b[0]) + 66'(a[1] * b[1]) + 66'(a[2] * b[2]);
                rs = clamp(round_prod(acc));
            end
            tva_pkg::MODE_CROSS: begin
                r[0] = clamp(round_prod(66'(a[1] * b[2]) - 66'(b[1] * a[2])));
                r[1] = clamp(round_prod(66'(b[0] * a[2]) - 66'(a[0] * b[2])));
                r[2] = clamp(round_prod(66'(a[0] * b[1]) - 66'(b[0] * a[1])));
            end
            default: begin
                sq = 0;
                for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
                len = root_round(sq);
                if (mode == tva_pkg::MODE_LEN) rs = clamp(len);
                else if (len == 0) r = a;
                else for (int i = 0; i < 3; i++) r[i] = clamp(quot_round(a[i], len));
            end
        endcase
        res.r_x = r[0][31:0];
        res.r_y = r[1][31:0];
        res.r_z = r[2][31:0];
        res.r_scalar = rs[31:0];
        res.range_error = sat_flag;
        return res;
    endfunction

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                        : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_word(input tva_pkg::t_mode mode, input logic [31:0] ax, ay, az,
            bx, by, bz, sc, input bit gaps);
        longint a[3], b[3];
        if (gaps) random_gap();
        start <= 1'b1;
        i_mode <= mode;
        i_a_x <= ax;
        i_a_y <= ay;
        i_a_z <= az;
        i_b_x <= bx;
        i_b_y <= by;
        i_b_z <= bz;
        i_scalar_in <= sc;
        a = '{longint'($signed(ax)), longint'($signed(ay)), longint'($signed(az))};
        b = '{longint'($signed(bx)), longint'($signed(by)), longint'($signed(bz))};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_alu(mode, a, b, longint'($signed(sc))));
        mode_count[mode]++;
        words_sent++;
    endtask

    task automatic finish_stream();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 3) - 1;
            3: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
            4: return 32'($signed($urandom_range(0, 32'h2000000)) - 32'sh1000000);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_vec_result exp_res;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with none expected");
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_r_x !== exp_res.r_x) begin
                    $error("r_x expected %0d actual %0d", exp_res.r_x, o_r_x);
                    errors++;
                end
                if (o_r_y !== exp_res.r_y) begin
                    $error("r_y expected %0d actual %0d", exp_res.r_y, o_r_y);
                    errors++;
                end
                if (o_r_z !== exp_res.r_z) begin
                    $error("r_z expected %0d actual %0d", exp_res.r_z, o_r_z);
                    errors++;
                end
                if (o_r_scalar !== exp_res.r_scalar) begin
                    $error("r_scalar expected %0d actual %0d", exp_res.r_scalar, o_r_scalar);
                    errors++;
                end
                if (o_range_error !== exp_res.range_error) begin
                    $error("range_error expected %0b actual %0b",
                           exp_res.range_error, o_range_error);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed_extremes();
        localparam logic [31:0] MX = 32'h7fffffff;
        localparam logic [31:0] MN = 32'h80000000;
        localparam logic [31:0] ONE = 32'h00010000;
        send_word(tva_pkg::MODE_ADD, MX, MN, ONE, MX, MN, ~ONE + 1, 0, 0);
        send_word(tva_pkg::MODE_SUB, MX, MN, 0, MN, MX, 0, 0, 0);
        send_word(tva_pkg::MODE_SCALE, MX, MN, ONE, 0, 0, 0, MN, 0);
        send_word(tva_pkg::MODE_SCALE, 32'h00008000, 32'hffff8000, 3, 0, 0, 0, ONE >> 1, 0);
        send_word(tva_pkg::MODE_DIV, MX, MN, 0, 0, 0, 0, 0, 0);
        send_word(tva_pkg::MODE_DIV, MX, MN, ONE, 0, 0, 0, 1, 0);
        send_word(tva_pkg::MODE_DIV, 3, 32'hfffffffd, ONE, 0, 0, 0, 32'hfffe0000, 0);
        send_word(tva_pkg::MODE_DOT, MX, MN, MX, MX, MN, MX, 0, 0);
        send_word(tva_pkg::MODE_DOT, ONE, ONE, ONE, ONE, 32'hffff0000, 32'h00008000, 0, 0);
        send_word(tva_pkg::MODE_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 0);
        send_word(tva_pkg::MODE_CROSS, MX, MN, MX, MN, MX, MN, 0, 0);
        send_word(tva_pkg::MODE_LEN, MN, MN, MN, 0, 0, 0, 0, 0);
        send_word(tva_pkg::MODE_LEN, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0, 0);
        send_word(tva_pkg::MODE_NORM, 0, 0, 0, MX, MN, 1, MX, 0);
        send_word(tva_pkg::MODE_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
        send_word(tva_pkg::MODE_NORM, MN, 0, 0, 0, 0, 0, 0, 0);
        send_word(tva_pkg::MODE_NORM, 32'h00030000, 32'hfffc0000, 1, 0, 0, 0, 0, 0);
        send_word(tva_pkg::MODE_LEN, 1, 0, 0, 0, 0, 0, 0, 0);
        finish_stream();
    endtask

    task automatic test_random_words();
        repeat (900) begin
            send_word(tva_pkg::t_mode'($urandom_range(0, 7)),
                      rand_word(), rand_word(), rand_word(),
                      rand_word(), rand_word(), rand_word(),
                      ($urandom_range(0, 15) == 0) ? 32'h0 : rand_word(),
                      $urandom_range(0, 3) != 0);
        end
        finish_stream();
    endtask

    task automatic test_drain();
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_random_words();
        test_drain();
        $display("sent %0d words, checked %0d results", words_sent, results_seen);
        $display("per mode add..norm: %0d %0d %0d %0d %0d %0d %0d %0d",
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3],
                 mode_count[4], mode_count[5], mode_count[6], mode_count[7]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[three_vector_alu_unit] OK");
        end else begin
            $display("[three_vector_alu_unit] ERROR");
        end
        $finish;
    end
endmodule

FILE: three_vector_alu_unit.f
+incdir+hdl
hdl/tva_pkg.sv
hdl/tva_lane.sv
hdl/tva_sqrt.sv
hdl/tva_div.sv
hdl/three_vector_alu_unit.sv
test/three_vector_alu_unit_test.sv
